>>> src/imdu_pkg.sv
// Package for the integer multiply-divide unit.
// Holds the opcode type, the word that moves down the cell chain and the sizes.
// No dependencies.
package imdu_pkg;

    localparam int XLEN      = 64;
    localparam int NUM_CELLS = 64;

    typedef enum logic [2:0] {
        OP_MADD   = 3'd0,
        OP_MSUB   = 3'd1,
        OP_UMADDL = 3'd2,
        OP_SMADDL = 3'd3,
        OP_UMULH  = 3'd4,
        OP_SMULH  = 3'd5,
        OP_UDIV   = 3'd6,
        OP_SDIV   = 3'd7
    } op_t;

    // acc holds the partial product, or the partial remainder in its low half.
    // x is the multiplicand or divisor, y the multiplier or the dividend that
    // turns into the quotient. c is the addend, or the signed high-half fixup.
    typedef struct packed {
        op_t               op;
        logic              wide;
        logic              dz;
        logic              negq;
        logic [XLEN-1:0]   c;
        logic [2*XLEN-1:0] acc;
        logic [XLEN-1:0]   x;
        logic [XLEN-1:0]   y;
    } word_t;

endpackage

>>> src/imdu_prep.sv
// Operand preparation stage of the integer multiply-divide unit.
// Decodes the opcode and conditions operands for the cell chain. Uses imdu_pkg.
module imdu_prep import imdu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  op_t             op,
    input  logic            wide,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    input  logic [XLEN-1:0] c,
    output logic            valid_out,
    output word_t           word_out
);

    logic            valid_reg;
    word_t           word_reg;
    word_t           word_next;
    logic [XLEN-1:0] sa;
    logic [XLEN-1:0] sb;
    logic [XLEN-1:0] za;
    logic [XLEN-1:0] zb;
    logic [XLEN-1:0] da;
    logic [XLEN-1:0] db;

    always_comb
    begin
        za = {32'd0, a[31:0]};
        zb = {32'd0, b[31:0]};
        sa = {{32{a[31]}}, a[31:0]};
        sb = {{32{b[31]}}, b[31:0]};
        da = '0;
        db = '0;
        word_next      = '0;
        word_next.op   = op;
        word_next.wide = wide;
        word_next.c    = c;
        case (op)
            OP_UMADDL:
            begin
                word_next.x = za;
                word_next.y = zb;
            end
            OP_SMADDL:
            begin
                word_next.x = sa;
                word_next.y = sb;
            end
            OP_SMULH:
            begin
                word_next.x = a;
                word_next.y = b;
                word_next.c = (a[XLEN-1] ? b : '0) + (b[XLEN-1] ? a : '0);
            end
            OP_UDIV:
            begin
                word_next.x  = wide ? b : zb;
                word_next.y  = wide ? a : za;
                word_next.dz = (word_next.x == '0);
            end
            OP_SDIV:
            begin
                da = wide ? a : sa;
                db = wide ? b : sb;
                word_next.negq = da[XLEN-1] ^ db[XLEN-1];
                word_next.x    = db[XLEN-1] ? (XLEN'(0) - db) : db;
                word_next.y    = da[XLEN-1] ? (XLEN'(0) - da) : da;
                word_next.dz   = (db == '0);
            end
            default:
            begin
                word_next.x = a;
                word_next.y = b;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

>>> src/imdu_cell.sv
// One cell of the multiply-divide chain: one shift-add or one restoring
// divide step per cell, then a register. Uses imdu_pkg.
module imdu_cell import imdu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  word_t word_in,
    output logic  valid_out,
    output word_t word_out
);

    logic        valid_reg;
    word_t       word_reg;
    word_t       word_next;
    logic        is_div;
    logic [XLEN:0] sum;
    logic [XLEN:0] shifted;
    logic [XLEN:0] diff;
    logic          qbit;

    always_comb
    begin
        is_div    = (word_in.op == OP_UDIV) || (word_in.op == OP_SDIV);
        word_next = word_in;
        sum     = {1'b0, word_in.acc[2*XLEN-1:XLEN]}
                  + (word_in.y[0] ? {1'b0, word_in.x} : '0);
        shifted = {word_in.acc[XLEN-1:0], word_in.y[XLEN-1]};
        diff    = shifted - {1'b0, word_in.x};
        qbit    = (shifted >= {1'b0, word_in.x});
        if (is_div)
        begin
            word_next.acc = {{XLEN{1'b0}}, qbit ? diff[XLEN-1:0] : shifted[XLEN-1:0]};
            word_next.y   = {word_in.y[XLEN-2:0], qbit};
        end
        else
        begin
            word_next.acc = {sum, word_in.acc[XLEN-1:1]};
            word_next.y   = {1'b0, word_in.y[XLEN-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

>>> src/imdu_post.sv
// Result formation for the multiply-divide unit: accumulate, fixups, width.
// Combinational; uses imdu_pkg.
module imdu_post import imdu_pkg::*;
(
    input  word_t           word_in,
    output logic [XLEN-1:0] result
);

    logic [XLEN-1:0] lo;
    logic [XLEN-1:0] hi;
    logic [XLEN-1:0] r;

    always_comb
    begin
        lo = word_in.acc[XLEN-1:0];
        hi = word_in.acc[2*XLEN-1:XLEN];
        case (word_in.op)
            OP_MADD:   r = word_in.c + lo;
            OP_MSUB:   r = word_in.c - lo;
            OP_UMADDL: r = word_in.c + lo;
            OP_SMADDL: r = word_in.c + lo;
            OP_UMULH:  r = hi;
            OP_SMULH:  r = hi - word_in.c;
            OP_UDIV:   r = word_in.dz ? '0 : word_in.y;
            default:   r = word_in.dz ? '0
                           : (word_in.negq ? (XLEN'(0) - word_in.y) : word_in.y);
        endcase
        if (!word_in.wide && (word_in.op == OP_MADD || word_in.op == OP_MSUB
                              || word_in.op == OP_UDIV || word_in.op == OP_SDIV))
        begin
            r = {32'd0, r[31:0]};
        end
        result = r;
    end

endmodule

>>> src/integer_multiply_divide_unit.sv
// Top level of the integer multiply-divide unit.
// Instantiates imdu_prep, a chain of imdu_cell and imdu_post; uses imdu_pkg.
//
// Usage:
// The input channel takes one word per cycle: opcode, wide and three 64-bit
// operands. A word is accepted on a rising edge where in_valid is high and
// in_stall is low. The output channel presents one result word per input
// word, in order, accepted where out_valid is high and out_stall is low.
// A word passes through one preparation stage, 64 chain cells (one shift-add
// step of the multiply or one restoring step of the divide per cell) and the
// output register. Throughput is one word per cycle while the output is not
// stalled, set by the cell chain, which advances as a whole in every such cycle.
// When the receiver stalls a waiting result, the whole chain holds and
// in_stall rises in the same cycle; words already in flight are kept. Bubbles
// in the chain do not block anything and move on with the rest.
// Reset clears all valid bits, so the unit comes up empty; data registers
// are not reset. Divide by zero gives zero, and signed overflow of a divide
// returns the most negative value of the operation width.
module integer_multiply_divide_unit import imdu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      opcode,
    input  logic            wide,
    input  logic [XLEN-1:0] operand_a,
    input  logic [XLEN-1:0] operand_b,
    input  logic [XLEN-1:0] operand_c,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [XLEN-1:0] result
);

    logic            adv;
    logic            cell_valid [NUM_CELLS+1];
    word_t           cell_word  [NUM_CELLS+1];
    logic            out_valid_reg;
    logic [XLEN-1:0] result_reg;
    logic [XLEN-1:0] post_result;

    // The chain only stops when a finished result cannot leave.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    imdu_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (in_valid),
        .op        (op_t'(opcode)),
        .wide      (wide),
        .a         (operand_a),
        .b         (operand_b),
        .c         (operand_c),
        .valid_out (cell_valid[0]),
        .word_out  (cell_word[0])
    );

    // Each cell retires one bit of multiplier or one quotient bit.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        imdu_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (cell_valid[i]),
            .word_in   (cell_word[i]),
            .valid_out (cell_valid[i+1]),
            .word_out  (cell_word[i+1])
        );
    end

    imdu_post u_post
    (
        .word_in (cell_word[NUM_CELLS]),
        .result  (post_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cell_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= post_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // An accepted word lands in the preparation stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cell_valid[0])
        else $error("accepted word did not enter the chain");

    // A held chain keeps its first and last cell occupancy.
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(cell_valid[0]) && $stable(cell_valid[NUM_CELLS])))
        else $error("chain moved while stalled");

    // A word in the first cell moves to the second when the chain advances.
    a_cell_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cell_valid[0]) |=> cell_valid[1])
        else $error("word lost between cells");

    // The last cell's word reaches the output when the chain advances.
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cell_valid[NUM_CELLS]) |=> out_valid)
        else $error("result lost at output");

endmodule
